[src/fem_pkg.sv]
// Shared types, constants and the pixel decision function of the fractal edge marker.
package fem_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 1024;
	localparam int unsigned CFG_W         = 11;
	localparam int unsigned PIX_W         = 16;
	localparam int unsigned POS_W         = 10;
	localparam int unsigned ADDR_W        = 3;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned TDATA_OUT_W   = 40;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QCNT_W        = 3;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
	localparam logic [CFG_W-1:0] HEIGHT_MIN   = CFG_W'(2);
	localparam logic [CFG_W-1:0] HEIGHT_MAX   = CFG_W'(1024);

	// register select is paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic             forced;
		logic             border;
		logic [PIX_W-1:0] color;
	} judge_t;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] color;
		logic             border;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} result_t;

	function automatic judge_t judge(input logic first_col, input logic at_end,
			input logic [PIX_W-1:0] ctr, input logic [PIX_W-1:0] up,
			input logic [PIX_W-1:0] dn, input logic [PIX_W-1:0] rt,
			input logic forced);
		judge_t j;
		j.forced = forced;
		j.border = 1'b0;
		j.color  = '0;
		if (first_col) begin
			j.border = 1'b1;
			j.forced = 1'b0;
		end else if (forced) begin
			j.color  = ctr;
			j.forced = 1'b0;
		end else if (at_end) begin
			j.border = 1'b1;
		end else if (ctr > up || ctr > dn) begin
			j.color = ctr;
		end else if (ctr < rt) begin
			j.forced = 1'b1;
		end else if (ctr > rt) begin
			j.color = ctr;
		end
		return j;
	endfunction

endpackage

[src/fem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fem_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/fractal_edge_marker.sv]
// Top level of the fractal edge marker: line buffers, edge decision and result queue.
//
// channel   direction  request                     fields (low bit up)
// s_axis    in         one pixel iteration count   tdata: iter_value[15:0]
// m_axis    out        one edge result             tdata: out_row, out_col, color_index
//                                                  tuser: is_border; tlast: frame_last
// apb       in         register write / read       0x0 image_width, 0x4 image_height
//
// Pixels are taken one per clock; results for row r leave while row r+1 arrives.
// Bottom row: each pixel after the first gives two results and the last one three; the
// single-result output then holds back the input rate there.
// Each register write holds s_axis_tready low through fetch_ctr and fetch_rt to reread the
// line buffers, two RAMs read one (older) and two (newer) columns ahead; no clearing pass after reset.
// A stalled output fills a four-entry result queue, then s_axis_tready drops.
module fractal_edge_marker
	import fem_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,   // iter_value[15:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // out_row[9:0], out_col[19:10], color_index[35:20]
	output logic                   m_axis_tuser,   // is_border
	output logic                   m_axis_tlast,   // frame_last
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam int unsigned XW    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int unsigned ROW_X = POS_W + 1;

	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic             forced_lag_q;
	logic             forced_last_q;
	logic [PIX_W-1:0] prev_q;
	logic [PIX_W-1:0] ctr_q;
	logic [PIX_W-1:0] ctr_prev_q;

	result_t          queue_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0] count_q;

	logic             cfg_wr;
	logic             fetch_ctr_q;
	logic             fetch_rt_q;

	logic [XW-1:0]    w_x;
	logic [ROW_X-1:0] h_x;
	logic [XW-1:0]    c_x;
	logic [ROW_X-1:0] r_x;
	logic [ROW_X-1:0] r_inc;
	logic [XW-1:0]    c1_x;
	logic [XW-1:0]    c2_x;
	logic [COL_W-1:0] cur_col;
	logic [COL_W-1:0] older_raddr;
	logic [COL_W-1:0] newer_raddr;
	logic [COL_W-1:0] older_rsel;
	logic [COL_W-1:0] newer_rsel;
	logic             older_re;
	logic             newer_re;
	logic [PIX_W-1:0] older_rd;
	logic [PIX_W-1:0] newer_rd;
	logic [PIX_W-1:0] px;
	logic [PIX_W-1:0] up_lag;

	logic             accept;
	logic             pop;
	logic             has_lag;
	logic             has_a;
	logic             has_b;
	logic             last_row;
	logic [QCNT_W-1:0] n_res;
	logic [QCNT_W-1:0] base;
	logic [QCNT_W-1:0] k_a;
	logic [QCNT_W-1:0] k_b;

	judge_t           j_lag;
	judge_t           j_a;
	judge_t           j_b;
	result_t          res_lag;
	result_t          res_a;
	result_t          res_b;

	logic [COL_W-1:0] nxt_col;
	logic [POS_W-1:0] nxt_row;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_IMAGE_WIDTH) begin
				image_width_q <= pwdata[CFG_W-1:0];
			end else begin
				image_height_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// reread of the line buffers at the current and next column after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_ctr_q <= 1'b0;
			fetch_rt_q  <= 1'b0;
		end else begin
			fetch_ctr_q <= cfg_wr;
			fetch_rt_q  <= fetch_ctr_q && !cfg_wr;
		end
	end

	// effective frame size and current position
	always_comb begin
		if (XW'(image_width_q) < XW'(3)) begin
			w_x = XW'(3);
		end else if (XW'(image_width_q) > XW'(MAX_WIDTH)) begin
			w_x = XW'(MAX_WIDTH);
		end else begin
			w_x = XW'(image_width_q);
		end
		if (image_height_q < HEIGHT_MIN) begin
			h_x = ROW_X'(HEIGHT_MIN);
		end else if (image_height_q > HEIGHT_MAX) begin
			h_x = ROW_X'(HEIGHT_MAX);
		end else begin
			h_x = ROW_X'(image_height_q);
		end

		if (XW'(col_q) >= w_x) begin
			c_x = '0;
			r_x = ROW_X'(row_q) + ROW_X'(1);
		end else begin
			c_x = XW'(col_q);
			r_x = ROW_X'(row_q);
		end
		if (r_x >= h_x) begin
			r_x = '0;
		end
		cur_col = c_x[COL_W-1:0];

		c1_x = c_x + XW'(1);
		c2_x = c_x + XW'(2);
		older_raddr = (c1_x >= w_x) ? '0 : c1_x[COL_W-1:0];
		newer_raddr = (c2_x >= w_x) ? COL_W'(c2_x - w_x) : c2_x[COL_W-1:0];

		r_inc = r_x + ROW_X'(1);
		if (c1_x >= w_x) begin
			nxt_col = '0;
			nxt_row = (r_inc >= h_x) ? '0 : r_inc[POS_W-1:0];
		end else begin
			nxt_col = c1_x[COL_W-1:0];
			nxt_row = r_x[POS_W-1:0];
		end
	end

	// result count of the pixel at the head of the input
	always_comb begin
		last_row = (r_x == h_x - ROW_X'(1));
		has_lag  = (r_x != '0);
		has_a    = last_row && (c_x != '0);
		has_b    = last_row && (c1_x == w_x);
		n_res    = QCNT_W'(has_lag) + QCNT_W'(has_a) + QCNT_W'(has_b);
		k_a      = QCNT_W'(has_lag);
		k_b      = QCNT_W'(has_lag) + QCNT_W'(has_a);
	end

	assign s_axis_tready = !fetch_ctr_q && !fetch_rt_q &&
		((count_q + n_res) <= QCNT_W'(QUEUE_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign px            = s_axis_tdata;

	// line buffer read ports
	always_comb begin
		if (fetch_ctr_q) begin
			older_rsel = cur_col;
			newer_rsel = cur_col;
		end else if (fetch_rt_q) begin
			older_rsel = older_raddr;
			newer_rsel = older_raddr;
		end else begin
			older_rsel = older_raddr;
			newer_rsel = newer_raddr;
		end
		older_re = accept || fetch_ctr_q;
		newer_re = accept || fetch_ctr_q || fetch_rt_q;
	end

	// line buffers
	fem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_older_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (cur_col),
		.wdata (ctr_q),
		.re    (older_re),
		.raddr (older_rsel),
		.rdata (older_rd)
	);

	fem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_newer_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (cur_col),
		.wdata (px),
		.re    (newer_re),
		.raddr (newer_rsel),
		.rdata (newer_rd)
	);

	// edge decisions
	always_comb begin
		up_lag = (r_x == ROW_X'(1)) ? ctr_q : older_rd;
		j_lag  = judge(c_x == '0, c1_x >= w_x, ctr_q, up_lag, px, newer_rd, forced_lag_q);
		j_a    = judge(c_x == XW'(1), 1'b0, prev_q, ctr_prev_q, prev_q, px, forced_last_q);
		j_b    = judge(1'b0, 1'b1, px, px, px, px, has_a ? j_a.forced : forced_last_q);

		res_lag.row    = POS_W'(r_x - ROW_X'(1));
		res_lag.col    = POS_W'(c_x);
		res_lag.border = j_lag.border;
		res_lag.color  = j_lag.color;
		res_lag.last   = 1'b0;

		res_a.row      = POS_W'(r_x);
		res_a.col      = POS_W'(c_x - XW'(1));
		res_a.border   = j_a.border;
		res_a.color    = j_a.color;
		res_a.last     = 1'b0;

		res_b.row      = POS_W'(r_x);
		res_b.col      = POS_W'(c_x);
		res_b.border   = j_b.border;
		res_b.color    = j_b.color;
		res_b.last     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			forced_lag_q  <= 1'b0;
			forced_last_q <= 1'b0;
		end else if (accept) begin
			col_q <= nxt_col;
			row_q <= nxt_row;
			if (has_lag) begin
				forced_lag_q <= j_lag.forced;
			end
			if (has_b) begin
				forced_last_q <= j_b.forced;
			end else if (has_a) begin
				forced_last_q <= j_a.forced;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_q     <= px;
			ctr_q      <= newer_rd;
			ctr_prev_q <= ctr_q;
		end else if (fetch_rt_q) begin
			ctr_q      <= newer_rd;
		end
	end

	// result queue, head is the output register
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign base = count_q - QCNT_W'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + (accept ? n_res : '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (accept && has_lag && (QCNT_W'(i) == base)) begin
				queue_q[i] <= res_lag;
			end else if (accept && has_a && (QCNT_W'(i) == base + k_a)) begin
				queue_q[i] <= res_a;
			end else if (accept && has_b && (QCNT_W'(i) == base + k_b)) begin
				queue_q[i] <= res_b;
			end else if (pop && (i < QUEUE_DEPTH - 1)) begin
				queue_q[i] <= queue_q[(i + 1) % QUEUE_DEPTH];
			end
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = TDATA_OUT_W'({queue_q[0].color, queue_q[0].col, queue_q[0].row});
	assign m_axis_tuser  = queue_q[0].border;
	assign m_axis_tlast  = queue_q[0].last;

endmodule

[dv/tb_fractal_edge_marker.sv]
// Self-checking testbench for the fractal edge marker with a predicting scoreboard.
`timescale 1ns / 1ps

class edge_checker;
	bit [15:0] older_line [fem_pkg::MAX_WIDTH_DEF];
	bit [15:0] newer_line [fem_pkg::MAX_WIDTH_DEF];
	int unsigned row_pos, col_pos;
	bit forced_lag, forced_last;
	bit [15:0] prev_px;
	int unsigned width_reg, height_reg;
	fem_pkg::result_t results_due [$];
	int errors;

	function new();
		width_reg  = 640;
		height_reg = 480;
		row_pos = 0;
		col_pos = 0;
		forced_lag  = 0;
		forced_last = 0;
		prev_px = '0;
		errors  = 0;
	endfunction

	function void set_reg(logic sel, int unsigned value);
		if (sel == fem_pkg::REG_IMAGE_WIDTH)
			width_reg = value & 32'h7FF;
		else
			height_reg = value & 32'h7FF;
	endfunction

	function int unsigned eff_width();
		if (width_reg < 3)
			return 3;
		if (width_reg > fem_pkg::MAX_WIDTH_DEF)
			return fem_pkg::MAX_WIDTH_DEF;
		return width_reg;
	endfunction

	function int unsigned eff_height();
		if (height_reg < 2)
			return 2;
		if (height_reg > 1024)
			return 1024;
		return height_reg;
	endfunction

	function int unsigned frame_size();
		return eff_width() * eff_height();
	endfunction

	function int unsigned pending();
		return results_due.size();
	endfunction

	// rt only matters below the last column
	function void decide_edge(input int unsigned c, input int unsigned w,
			input bit [15:0] ctr, input bit [15:0] up, input bit [15:0] dn,
			input bit [15:0] rt, inout bit forced, output bit border,
			output bit [15:0] color);
		border = 1'b0;
		color  = '0;
		if (c == 0) begin
			border = 1'b1;
			forced = 1'b0;
		end else if (forced) begin
			color  = ctr;
			forced = 1'b0;
		end else if (c >= w - 1) begin
			border = 1'b1;
		end else if (ctr > up || ctr > dn) begin
			color = ctr;
		end else if (ctr < rt) begin
			forced = 1'b1;
		end else if (ctr > rt) begin
			color = ctr;
		end
	endfunction

	function void push_result(int unsigned r, int unsigned c, bit border,
			bit [15:0] color, bit last);
		fem_pkg::result_t e;
		e.row    = r[9:0];
		e.col    = c[9:0];
		e.border = border;
		e.color  = color;
		e.last   = last;
		results_due.push_back(e);
	endfunction

	function void note_pixel(bit [15:0] px);
		int unsigned w, h, r, c;
		bit [15:0] ctr, up, rt;
		bit border;
		bit [15:0] color;
		w = eff_width();
		h = eff_height();
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		// row above the incoming one is finished now
		if (r >= 1) begin
			ctr = newer_line[c];
			up  = (r == 1) ? ctr : older_line[c];
			rt  = (c + 1 < w) ? newer_line[c + 1] : 16'd0;
			decide_edge(c, w, ctr, up, px, rt, forced_lag, border, color);
			push_result(r - 1, c, border, color, 1'b0);
		end
		older_line[c] = newer_line[c];
		newer_line[c] = px;
		// bottom row is finished one pixel behind its own arrival
		if (r == h - 1) begin
			if (c >= 1) begin
				decide_edge(c - 1, w, prev_px, older_line[c - 1], prev_px, px,
					forced_last, border, color);
				push_result(r, c - 1, border, color, 1'b0);
			end
			if (c == w - 1) begin
				decide_edge(c, w, px, px, px, px, forced_last, border, color);
				push_result(r, c, border, color, 1'b1);
			end
		end
		prev_px = px;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function void check_result(fem_pkg::result_t got);
		fem_pkg::result_t exp;
		if (results_due.size() == 0) begin
			$error("unexpected result: row %0d col %0d", got.row, got.col);
			errors++;
			return;
		end
		exp = results_due.pop_front();
		if (got.row !== exp.row) begin
			$error("out_row: expected %0d, got %0d", exp.row, got.row);
			errors++;
		end
		if (got.col !== exp.col) begin
			$error("out_col: expected %0d, got %0d", exp.col, got.col);
			errors++;
		end
		if (got.border !== exp.border) begin
			$error("is_border: expected %0d, got %0d", exp.border, got.border);
			errors++;
		end
		if (got.color !== exp.color) begin
			$error("color_index: expected %0d, got %0d", exp.color, got.color);
			errors++;
		end
		if (got.last !== exp.last) begin
			$error("frame_last: expected %0d, got %0d", exp.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_fractal_edge_marker;
	import fem_pkg::*;

	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned RANDOM_PIXELS  = 260;
	localparam int unsigned LONG_HOLD      = 80;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata;   // iter_value[15:0]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // out_row[9:0], out_col[19:10], color_index[35:20]
	logic                   m_axis_tuser;   // is_border
	logic                   m_axis_tlast;   // frame_last
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	edge_checker sb;
	result_t     seen;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int unsigned rx_hold;
	int unsigned rx_gap;
	int unsigned stall_cycles;

	fractal_edge_marker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result sink: random back-pressure plus a long hold on request
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			m_axis_tready <= 1'b0;
			rx_hold--;
		end else if (rx_gap != 0) begin
			m_axis_tready <= 1'b0;
			rx_gap--;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			rx_gap = $urandom_range(0, 11);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				seen.row    = m_axis_tdata[9:0];
				seen.col    = m_axis_tdata[19:10];
				seen.color  = m_axis_tdata[35:20];
				seen.border = m_axis_tuser;
				seen.last   = m_axis_tlast;
				sb.check_result(seen);
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic logic [PIX_W-1:0] rand_px();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return PIX_W'($urandom_range(0, 3));
			5, 6:          return PIX_W'($urandom_range(0, 15));
			7:             return PIX_W'(16'hFFFF - $urandom_range(0, 2));
			default:       return PIX_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_pixel(rand_px());
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic prog_reg(input logic sel, input int unsigned value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(sel, value);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(value & 32'h7FF)) begin
			$error("prdata: expected %0d, got %0d", value & 32'h7FF, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		drain();
		prog_reg(REG_IMAGE_WIDTH, w);
		prog_reg(REG_IMAGE_HEIGHT, h);
	endtask

	initial begin
		logic [PIX_W-1:0] tiny_frame [6];
		logic [PIX_W-1:0] forced_frame [15];
		int unsigned random_sent;
		int unsigned w, h;

		tiny_frame   = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
		forced_frame = '{16'd9, 16'd9, 16'd9, 16'd9, 16'd9,
			16'd0, 16'd3, 16'd5, 16'd5, 16'd0,
			16'd9, 16'd2, 16'd7, 16'd7, 16'd9};
		sb = new();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold = 0;
		rx_gap  = 0;
		stall_cycles = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// smallest frame with extreme values
		set_frame(3, 2);
		foreach (tiny_frame[i]) send_pixel(tiny_frame[i]);
		// right neighbour forcing, equal neighbours, bottom row
		set_frame(5, 3);
		foreach (forced_frame[i]) send_pixel(forced_frame[i]);
		// registers below range clamp to 3 x 2
		set_frame(0, 1);
		send_random(sb.frame_size());

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// width shrinks mid-row beyond the current column
		set_frame(8, 5);
		send_random(21);
		drain();
		prog_reg(REG_IMAGE_WIDTH, 4);
		send_random(8);
		// height shrinks below the current row: new frame starts
		set_frame(4, 6);
		send_random(16);
		drain();
		prog_reg(REG_IMAGE_HEIGHT, 3);
		send_random(12);

		// sink holds off long enough to fill the result queue
		set_frame(12, 4);
		tx_idle_on = 1'b0;
		rx_hold = LONG_HOLD;
		send_random(sb.frame_size());

		random_sent = 0;
		while (random_sent < RANDOM_PIXELS) begin
			w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			h = $urandom_range(2, 6);
			set_frame(w, h);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			send_random(sb.frame_size());
			random_sent += w * h;
		end

		// closing frame with no idling
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_frame(9, 3);
		send_random(sb.frame_size());

		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
src/fem_pkg.sv
src/fem_ram.sv
src/fractal_edge_marker.sv
dv/tb_fractal_edge_marker.sv
